[rtl/core/dqsrch_pkg.sv]
// ----------------------------------------------------------------------------
// dqsrch_pkg
// Shared types and constants for the searchable double-ended byte queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dqsrch_pkg;

   localparam int DEPTH_DEFAULT      = 64;
   localparam int ITEM_WIDTH_DEFAULT = 8;

   // fixed port widths
   localparam int REQ_W   = 3;
   localparam int VALUE_W = 8;
   localparam int POS_W   = 8;
   localparam int FPOS_W  = 7;
   localparam int COUNT_W = 7;

   typedef enum logic [REQ_W-1:0] {
      REQ_PUSH_FRONT = 3'd0,
      REQ_PUSH_BACK  = 3'd1,
      REQ_POP_FRONT  = 3'd2,
      REQ_POP_BACK   = 3'd3,
      REQ_CLEAR      = 3'd4,
      REQ_READ_POS   = 3'd5,
      REQ_FIND       = 3'd6
   } req_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RDATA,
      ST_SCAN
   } fsm_state_type;

endpackage

`default_nettype wire

[rtl/core/deque_with_position_and_value_search.sv]
// ----------------------------------------------------------------------------
// deque_with_position_and_value_search
// Bounded double-ended byte queue on a ring, with read by position and find.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low. The
//   request code picks push front/back, pop front/back, clear, read by
//   1-based position (0 reads the front) or find the first matching value.
//   Every request gives exactly one response, shown for one cycle with
//   rsp_valid high; rsp_entry_count is the item count after the request.
//   The response is registered after the request passes these states in order:
//     push, pop, clear, unused code : DECODE
//     read by position              : DECODE, then RDATA on a hit (registered storage read)
//     find                          : DECODE, then SCAN for each entry compared,
//                                     at most DEPTH entries
//   Find walks the ring one entry per cycle from the front through the
//   single storage read port and one comparator; busy stays high until the
//   response is out, and the next request may arrive in the response cycle.
//   Reset empties the queue; storage contents are not cleared. The receiver
//   cannot stall: each response is taken in the cycle it is shown.
// ----------------------------------------------------------------------------
`default_nettype none

module deque_with_position_and_value_search
   import dqsrch_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int ITEM_WIDTH = ITEM_WIDTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [REQ_W-1:0]   req_type,
   input  wire logic [VALUE_W-1:0] req_item_value,
   input  wire logic [POS_W-1:0]   req_position,
   output logic                    rsp_valid,
   output logic                    rsp_ok,
   output logic [VALUE_W-1:0]      rsp_read_value,
   output logic [FPOS_W-1:0]       rsp_found_position,
   output logic [COUNT_W-1:0]      rsp_entry_count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;

   fsm_state_type         state_ff, state_in;
   req_code_type          req_ff, req_in;
   logic [ITEM_WIDTH-1:0] value_ff, value_in;
   logic [POS_W-1:0]      position_ff, position_in;
   logic [AW-1:0]         front_ff, front_in;
   logic [CW-1:0]         total_ff, total_in;
   logic [CW-1:0]         scan_ff, scan_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ok_ff, rsp_ok_in;
   logic [VALUE_W-1:0]    rsp_read_value_ff, rsp_read_value_in;
   logic [FPOS_W-1:0]     rsp_found_position_ff, rsp_found_position_in;

   logic                  accept;
   logic                  full;
   logic                  empty;
   logic [POS_W-1:0]      pos_eff;
   logic                  read_hit;
   logic [AW-1:0]         pos_offset;
   logic [CW-1:0]         scan_next;
   logic [AW-1:0]         front_dec;
   logic [AW-1:0]         offset;
   logic [AW:0]           slot_sum;
   logic [AW-1:0]         slot;
   logic                  match;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [ITEM_WIDTH-1:0] rd_data;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign full     = (total_ff == CW'(DEPTH));
   assign empty    = (total_ff == '0);
   assign pos_eff  = (position_ff == '0) ? POS_W'(1) : position_ff;
   assign read_hit = (PW'(pos_eff) <= PW'(total_ff));
   assign pos_offset = AW'(pos_eff - POS_W'(1));
   assign scan_next  = scan_ff + CW'(1);
   assign front_dec  = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);
   assign match      = (rd_data == value_ff);

   // shared ring-slot adder: front plus offset, wrapped at DEPTH
   always_comb begin
      offset = '0;
      if (state_ff == ST_SCAN) begin
         offset = AW'(scan_next);
      end else begin
         case (req_ff)
            REQ_PUSH_BACK: offset = AW'(total_ff);
            REQ_POP_FRONT: offset = AW'(1);
            REQ_READ_POS:  offset = pos_offset;
            default:       offset = '0;
         endcase
      end
   end

   assign slot_sum = {1'b0, front_ff} + {1'b0, offset};
   assign slot     = (slot_sum >= (AW+1)'(DEPTH)) ? AW'(slot_sum - (AW+1)'(DEPTH))
                                                  : slot_sum[AW-1:0];

   assign wr_en   = (state_ff == ST_DECODE) && !full &&
                    ((req_ff == REQ_PUSH_FRONT) || (req_ff == REQ_PUSH_BACK));
   assign wr_addr = (req_ff == REQ_PUSH_FRONT) ? front_dec : slot;

   dqsrch_ring #(
      .DEPTH      (DEPTH),
      .ITEM_WIDTH (ITEM_WIDTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (value_ff),
      .rd_addr (slot),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if ((req_ff == REQ_READ_POS) && read_hit) begin
               state_in = ST_RDATA;
            end else if ((req_ff == REQ_FIND) && !empty) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RDATA: state_in = ST_IDLE;
         ST_SCAN: begin
            if (match || (scan_next == total_ff)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and response
   always_comb begin
      req_in                = req_ff;
      value_in              = value_ff;
      position_in           = position_ff;
      front_in              = front_ff;
      total_in              = total_ff;
      scan_in               = scan_ff;
      rsp_valid_in          = 1'b0;
      rsp_ok_in             = 1'b0;
      rsp_read_value_in     = '0;
      rsp_found_position_in = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in      = req_code_type'(req_type);
               value_in    = ITEM_WIDTH'(req_item_value);
               position_in = req_position;
            end
         end
         ST_DECODE: begin
            scan_in = '0;
            case (req_ff)
               REQ_PUSH_FRONT: begin
                  rsp_valid_in = 1'b1;
                  if (!full) begin
                     front_in  = front_dec;
                     total_in  = total_ff + CW'(1);
                     rsp_ok_in = 1'b1;
                  end
               end
               REQ_PUSH_BACK: begin
                  rsp_valid_in = 1'b1;
                  if (!full) begin
                     total_in  = total_ff + CW'(1);
                     rsp_ok_in = 1'b1;
                  end
               end
               REQ_POP_FRONT: begin
                  rsp_valid_in = 1'b1;
                  if (!empty) begin
                     front_in  = slot;
                     total_in  = total_ff - CW'(1);
                     rsp_ok_in = 1'b1;
                  end
               end
               REQ_POP_BACK: begin
                  rsp_valid_in = 1'b1;
                  if (!empty) begin
                     total_in  = total_ff - CW'(1);
                     rsp_ok_in = 1'b1;
                  end
               end
               REQ_CLEAR: begin
                  rsp_valid_in = 1'b1;
                  rsp_ok_in    = !empty;
                  total_in     = '0;
               end
               REQ_READ_POS: begin
                  // hit waits in ST_RDATA for the registered storage read
                  rsp_valid_in = !read_hit;
               end
               REQ_FIND: begin
                  rsp_valid_in = empty;
               end
               default: begin
                  rsp_valid_in = 1'b1;
               end
            endcase
         end
         ST_RDATA: begin
            rsp_valid_in      = 1'b1;
            rsp_ok_in         = 1'b1;
            rsp_read_value_in = VALUE_W'(rd_data);
         end
         ST_SCAN: begin
            scan_in = scan_next;
            if (match) begin
               rsp_valid_in          = 1'b1;
               rsp_ok_in             = 1'b1;
               rsp_found_position_in = FPOS_W'(scan_next);
            end else if (scan_next == total_ff) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            scan_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff                <= req_in;
      value_ff              <= value_in;
      position_ff           <= position_in;
      scan_ff               <= scan_in;
      rsp_ok_ff             <= rsp_ok_in;
      rsp_read_value_ff     <= rsp_read_value_in;
      rsp_found_position_ff <= rsp_found_position_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_read_value     = rsp_read_value_ff;
   assign rsp_found_position = rsp_found_position_ff;
   assign rsp_entry_count    = COUNT_W'(total_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a request in flight");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two responses in a row");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_ff < total_ff))
      else $error("find walked past the last entry");

endmodule

`default_nettype wire

[rtl/core/dqsrch_ring.sv]
// ----------------------------------------------------------------------------
// dqsrch_ring
// Ring storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dqsrch_ring
   import dqsrch_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int ITEM_WIDTH = ITEM_WIDTH_DEFAULT,
   localparam int AW        = $clog2(DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [AW-1:0]         wr_addr,
   input  wire logic [ITEM_WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]         rd_addr,
   output logic      [ITEM_WIDTH-1:0] rd_data
);

   logic [ITEM_WIDTH-1:0] mem_ff [DEPTH];
   logic [ITEM_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
